>>> rtl/core/rtpjb_pkg.sv
package rtpjb_pkg;
    localparam int DEPTH     = 64;
    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int WIN_W     = 7;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SLOT_W    = 1 + 16 + 4 + 64;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_ANCHOR = 2'd2;

    localparam logic [3:0] ST_STORED   = 4'd0;
    localparam logic [3:0] ST_BADLEN   = 4'd1;
    localparam logic [3:0] ST_TOO_OLD  = 4'd2;
    localparam logic [3:0] ST_TOO_NEW  = 4'd3;
    localparam logic [3:0] ST_DUP      = 4'd4;
    localparam logic [3:0] ST_POPPED   = 4'd5;
    localparam logic [3:0] ST_EMPTY    = 4'd6;
    localparam logic [3:0] ST_CONCEAL  = 4'd7;
    localparam logic [3:0] ST_WAIT     = 4'd8;
    localparam logic [3:0] ST_ANCHORED = 4'd9;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_HOLD   = 1'b1;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction
endpackage

>>> rtl/core/rtpjb_in_if.sv
interface rtpjb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] seq;
    logic [10:0] length;
    logic [63:0] payload;
    logic [10:0] out_capacity;
    modport source (output valid, mode, seq, length, payload, out_capacity, input ready);
    modport sink (input valid, mode, seq, length, payload, out_capacity, output ready);
endinterface

>>> rtl/core/rtpjb_out_if.sv
interface rtpjb_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] seq_out;
    logic [3:0]  length_out;
    logic [63:0] payload_out;
    logic [15:0] gap_first;
    logic [6:0]  gap_count;
    modport source (output valid, status, seq_out, length_out, payload_out, gap_first,
                    gap_count, input ready);
    modport sink (input valid, status, seq_out, length_out, payload_out, gap_first,
                  gap_count, output ready);
endinterface

>>> rtl/core/rtpjb_ram.sv
module rtpjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/rtp_reorder_jitter_buffer.sv
// channel | dir | fields
// in      | in  | mode, seq, length, payload, out_capacity
// out     | out | status, seq_out, length_out, payload_out, gap_first, gap_count
// cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data (0 window_size, 1 hold_limit)
// One word at a time. A 16-step remainder pass finds the slot index, read through the
// single RAM read port; a second pass starts the front gap walk (up to window), which
// steps each slot through S_GEVAL, S_GCHK and S_GWAIT. Empty or unstarted words skip the second pass and the gap walk.
// Reset or a window_size write runs a clearing pass over DEPTH slots.
// A finished result waits in the output register; the next word is taken meanwhile
// and holds before execute until that register is free.
module rtp_reorder_jitter_buffer
    import rtpjb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    rtpjb_in_if.sink    in_ch,
    rtpjb_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EXEC, S_GRD, S_GCHK, S_GWAIT, S_GEVAL, S_DONE
    } t_state;

    t_state      r_state;
    logic [IDX_W-1:0] r_clr;
    logic [WIN_W-1:0] r_win;
    logic [15:0] r_hold;
    logic [15:0] r_next, r_head;
    logic [CNT_W-1:0] r_held;
    logic        r_started;
    logic [1:0]  r_mode;
    logic [15:0] r_seq, r_probe;
    logic [10:0] r_len, r_cap;
    logic [63:0] r_data;
    logic [IDX_W-1:0] r_idx;
    logic [15:0] r_rem;
    logic [6:0]  r_part;
    logic [3:0]  r_bit;
    logic [CNT_W-1:0] r_k, r_kmax;
    logic        r_phase;
    logic        r_ovalid;
    logic [3:0]  r_status;
    logic [15:0] r_seq_out, r_gfirst;
    logic [3:0]  r_len_out;
    logic [63:0] r_pay_out;
    logic [6:0]  r_gcount;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [SLOT_W-1:0] wdata, rdata;
    logic             rv;
    logic [15:0]      rs;
    logic [3:0]       rl;
    logic [63:0]      rd;

    rtpjb_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    assign {rv, rs, rl, rd} = rdata;

    logic [WIN_W-1:0] weff;
    logic [15:0]      heff;
    always_comb begin
        weff = r_win;
        if (r_win == '0) weff = WIN_W'(1);
        else if (32'(r_win) > DEPTH) weff = WIN_W'(DEPTH);
        heff = 16'(weff) - 16'd1;
        if (r_hold != '0 && r_hold < 16'(weff)) heff = r_hold;
    end

    // restoring remainder by window, one bit per cycle except in cycles with a cfg write
    wire [7:0] dv_sh = {r_part, r_rem[15]};
    wire [7:0] dv_nx = (dv_sh >= 8'(weff)) ? dv_sh - 8'(weff) : dv_sh;

    wire hit = rv && rs == r_probe;
    wire [15:0] d_next = r_seq - r_next;
    wire [15:0] hn = r_head - r_next;
    wire [15:0] sp1 = r_seq + 16'd1;
    wire [15:0] hd = r_head - sp1;
    wire [3:0] popn = (11'(rl) > r_cap) ? r_cap[3:0] : rl;

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.status = r_status;
    assign out_ch.seq_out = r_seq_out;
    assign out_ch.length_out = r_len_out;
    assign out_ch.payload_out = r_pay_out;
    assign out_ch.gap_first = r_gfirst;
    assign out_ch.gap_count = r_gcount;

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = {1'b1, r_seq, r_len[3:0], r_data & byte_mask(r_len[3:0])};
        raddr = r_idx;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (r_state == S_EXEC) begin
            if (r_mode == MODE_INSERT && r_len != '0 && r_len <= 11'(MAX_BYTES)
                && !(d_next[15]) && d_next < 16'(weff) && !hit) begin
                we = 1'b1;
            end else if (r_mode == MODE_POP && r_started && r_held != '0 && hit) begin
                we = 1'b1;
                wdata = {1'b0, rs, rl, rd};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_win <= WIN_W'(64);
            r_hold <= '0;
            r_next <= '0;
            r_head <= '0;
            r_held <= '0;
            r_started <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WINDOW) begin
                    r_win <= i_cfg_data[WIN_W-1:0];
                    r_next <= '0;
                    r_head <= '0;
                    r_held <= '0;
                    r_started <= 1'b0;
                    r_clr <= '0;
                    r_state <= S_CLEAR;
                end else begin
                    r_hold <= i_cfg_data;
                end
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + 1'b1;
                        if (32'(r_clr) == DEPTH - 1) r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (in_ch.valid && in_ch.ready) begin
                            r_mode <= in_ch.mode;
                            r_seq <= in_ch.seq;
                            r_len <= in_ch.length;
                            r_data <= in_ch.payload;
                            r_cap <= in_ch.out_capacity;
                            r_state <= S_RD;
                            if (in_ch.mode == MODE_INSERT && !r_started
                                && in_ch.length != '0
                                && in_ch.length <= 11'(MAX_BYTES)) begin
                                r_next <= in_ch.seq;
                                r_head <= in_ch.seq;
                                r_started <= 1'b1;
                            end
                            r_probe <= (in_ch.mode == MODE_INSERT) ? in_ch.seq : r_next;
                            r_rem <= (in_ch.mode == MODE_INSERT) ? in_ch.seq : r_next;
                            r_part <= '0;
                            r_bit <= '0;
                            r_k <= '0;
                            r_phase <= 1'b0;
                        end
                    end
                    S_RD: begin
                        r_part <= dv_nx[6:0];
                        r_rem <= {r_rem[14:0], 1'b0};
                        r_bit <= r_bit + 4'd1;
                        if (r_bit == 4'd15) begin
                            r_idx <= dv_nx[IDX_W-1:0];
                            r_state <= S_GWAIT;
                        end
                    end
                    S_EXEC: begin
                        r_seq_out <= '0;
                        r_len_out <= '0;
                        r_pay_out <= '0;
                        r_state <= S_GRD;
                        case (r_mode)
                            MODE_INSERT: begin
                                if (r_len == '0 || r_len > 11'(MAX_BYTES))
                                    r_status <= ST_BADLEN;
                                else if (d_next[15]) r_status <= ST_TOO_OLD;
                                else if (d_next >= 16'(weff)) r_status <= ST_TOO_NEW;
                                else if (hit) r_status <= ST_DUP;
                                else begin
                                    r_status <= ST_STORED;
                                    if (!rv) r_held <= r_held + 1'b1;
                                    if (hd[15]) r_head <= sp1;
                                end
                            end
                            MODE_POP: begin
                                if (!r_started || r_held == '0) r_status <= ST_EMPTY;
                                else if (hit) begin
                                    r_status <= ST_POPPED;
                                    r_seq_out <= r_next;
                                    r_len_out <= popn;
                                    r_pay_out <= rd & byte_mask(popn);
                                    r_held <= r_held - 1'b1;
                                    r_next <= r_next + 16'd1;
                                end else if (hn > heff) begin
                                    r_status <= ST_CONCEAL;
                                    r_next <= r_next + 16'd1;
                                end else r_status <= ST_WAIT;
                            end
                            MODE_ANCHOR: begin
                                r_status <= ST_ANCHORED;
                                r_next <= r_seq;
                                r_head <= r_seq;
                                r_started <= 1'b1;
                            end
                            default: r_status <= ST_WAIT;
                        endcase
                    end
                    S_GRD: begin
                        r_gfirst <= '0;
                        r_gcount <= '0;
                        r_k <= '0;
                        r_kmax <= (hn < 16'(weff)) ? hn[CNT_W-1:0] : CNT_W'(weff);
                        if (!r_started || r_held == '0) r_state <= S_DONE;
                        else begin
                            r_probe <= r_next;
                            r_rem <= r_next;
                            r_part <= '0;
                            r_bit <= '0;
                            r_phase <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                    S_GWAIT: begin
                        if (r_phase) r_state <= S_GEVAL;
                        else if (!r_ovalid || out_ch.ready) r_state <= S_EXEC;
                    end
                    S_GEVAL: begin
                        if (hit) begin
                            r_state <= S_DONE;
                        end else if (r_k >= r_kmax) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_probe <= r_probe + 16'd1;
                            r_idx <= (32'(r_idx) + 1 >= 32'(weff)) ? '0 : r_idx + 1'b1;
                            r_state <= S_GCHK;
                        end
                    end
                    S_GCHK: r_state <= S_GWAIT;
                    S_DONE: begin
                        if (r_k != '0) begin
                            r_gfirst <= r_next;
                            r_gcount <= 7'(r_k);
                        end
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

>>> dv/rtpjb_chk.sv
module rtpjb_chk
    import rtpjb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    rtpjb_in_if         in_ch,
    rtpjb_out_if        out_ch,
    output int          o_fail_cnt,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] seq_out;
        logic [3:0]  length_out;
        logic [63:0] payload_out;
        logic [15:0] gap_first;
        logic [6:0]  gap_count;
    } jb_word_t;

    jb_word_t    pending_words[$];
    logic [6:0]  win_reg;
    logic [15:0] hold_reg;
    logic        mark[DEPTH];
    logic [15:0] mseq[DEPTH];
    logic [3:0]  mlen[DEPTH];
    logic [63:0] mdata[DEPTH];
    logic [15:0] nxt, head;
    int          held;
    logic        started;

    assign o_pending = pending_words.size();

    function automatic int win_eff();
        if (win_reg == 0) return 1;
        if (win_reg > DEPTH) return DEPTH;
        return int'(win_reg);
    endfunction

    function automatic int hold_eff();
        if (hold_reg != 0 && int'(hold_reg) < win_eff()) return int'(hold_reg);
        return win_eff() - 1;
    endfunction

    function automatic logic [63:0] keep_bytes(int n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic logic is_held(logic [15:0] s);
        int i;
        i = int'(s) % win_eff();
        return mark[i] && mseq[i] == s;
    endfunction

    function automatic logic seq_before(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15];
    endfunction

    task automatic flush_slots();
        for (int i = 0; i < DEPTH; i++) mark[i] = 1'b0;
        nxt = '0;
        head = '0;
        held = 0;
        started = 1'b0;
    endtask

    task automatic buffer_step(input logic [1:0] mode, input logic [15:0] s,
                               input logic [10:0] len, input logic [63:0] data,
                               input logic [10:0] cap);
        jb_word_t    w;
        int          i, n, span, miss;
        logic [15:0] d;
        w = '0;
        if (mode == MODE_INSERT) begin
            if (len == 0 || len > MAX_BYTES) begin
                w.status = ST_BADLEN;
            end else begin
                if (!started) begin
                    nxt = s;
                    head = s;
                    started = 1'b1;
                end
                d = s - nxt;
                i = int'(s) % win_eff();
                if (seq_before(s, nxt)) w.status = ST_TOO_OLD;
                else if (int'(d) >= win_eff()) w.status = ST_TOO_NEW;
                else if (mark[i] && mseq[i] == s) w.status = ST_DUP;
                else begin
                    if (!mark[i]) held++;
                    mark[i] = 1'b1;
                    mseq[i] = s;
                    mlen[i] = len[3:0];
                    mdata[i] = data & keep_bytes(int'(len));
                    if (seq_before(head, s + 16'd1)) head = s + 16'd1;
                    w.status = ST_STORED;
                end
            end
        end else if (mode == MODE_POP) begin
            if (!started || held == 0) begin
                w.status = ST_EMPTY;
            end else if (is_held(nxt)) begin
                i = int'(nxt) % win_eff();
                n = int'(mlen[i]);
                if (n > int'(cap)) n = int'(cap);
                w.status = ST_POPPED;
                w.seq_out = nxt;
                w.length_out = 4'(n);
                w.payload_out = mdata[i] & keep_bytes(n);
                mark[i] = 1'b0;
                held--;
                nxt = nxt + 16'd1;
            end else if (int'(16'(head - nxt)) > hold_eff()) begin
                w.status = ST_CONCEAL;
                nxt = nxt + 16'd1;
            end else begin
                w.status = ST_WAIT;
            end
        end else if (mode == MODE_ANCHOR) begin
            nxt = s;
            head = s;
            started = 1'b1;
            w.status = ST_ANCHORED;
        end else begin
            w.status = ST_WAIT;
        end
        if (started && held != 0 && !is_held(nxt)) begin
            span = int'(16'(head - nxt));
            miss = 0;
            for (int k = 0; k < span && k < win_eff(); k++) begin
                if (is_held(nxt + 16'(k))) break;
                miss++;
            end
            if (miss != 0) begin
                w.gap_first = nxt;
                w.gap_count = 7'(miss);
            end
        end
        pending_words.push_back(w);
    endtask

    task automatic compare_word();
        jb_word_t e;
        if (pending_words.size() == 0) begin
            $error("unexpected output word, status %0d", out_ch.status);
            o_fail_cnt++;
            return;
        end
        e = pending_words.pop_front();
        if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status);
            o_fail_cnt++;
        end
        if (out_ch.seq_out !== e.seq_out) begin
            $error("seq_out exp %0h got %0h", e.seq_out, out_ch.seq_out);
            o_fail_cnt++;
        end
        if (out_ch.length_out !== e.length_out) begin
            $error("length_out exp %0d got %0d", e.length_out, out_ch.length_out);
            o_fail_cnt++;
        end
        if (out_ch.payload_out !== e.payload_out) begin
            $error("payload_out exp %0h got %0h", e.payload_out, out_ch.payload_out);
            o_fail_cnt++;
        end
        if (out_ch.gap_first !== e.gap_first) begin
            $error("gap_first exp %0h got %0h", e.gap_first, out_ch.gap_first);
            o_fail_cnt++;
        end
        if (out_ch.gap_count !== e.gap_count) begin
            $error("gap_count exp %0d got %0d", e.gap_count, out_ch.gap_count);
            o_fail_cnt++;
        end
    endtask

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg = 7'd64;
            hold_reg = '0;
            flush_slots();
        end else begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) compare_word();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WINDOW) begin
                    win_reg = i_cfg_data[6:0];
                    flush_slots();
                end else begin
                    hold_reg = i_cfg_data;
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                buffer_step(in_ch.mode, in_ch.seq, in_ch.length, in_ch.payload,
                            in_ch.out_capacity);
        end
    end
endmodule

>>> dv/tb_rtp_reorder_jitter_buffer.sv
module tb_rtp_reorder_jitter_buffer;
    import rtpjb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_WINDOW;
    logic [15:0] i_cfg_data = '0;
    int          fail_cnt, pending;
    int          src_idle_pct, snk_idle_pct;
    longint      cyc = 0;
    logic [15:0] base;

    rtpjb_in_if  in_ch();
    rtpjb_out_if out_ch();

    rtp_reorder_jitter_buffer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    rtpjb_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch), .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_INSERT;
        in_ch.seq = '0;
        in_ch.length = '0;
        in_ch.payload = '0;
        in_ch.out_capacity = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > 3000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_word(input logic [1:0] mode, input logic [15:0] s,
                             input logic [10:0] len, input logic [63:0] data,
                             input logic [10:0] cap);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.seq <= s;
        in_ch.length <= len;
        in_ch.payload <= data;
        in_ch.out_capacity <= cap;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic rand_word(input logic [15:0] b, input int w);
        int r;
        r = $urandom_range(99);
        if (r < 50)
            send_word(MODE_INSERT, b + 16'($urandom_range(w + 1)),
                      11'($urandom_range(1, MAX_BYTES)), rnd64(), 11'($urandom_range(9)));
        else if (r < 85)
            send_word(MODE_POP, 16'($urandom()), 11'($urandom()), rnd64(),
                      ($urandom_range(3) == 0) ? 11'($urandom()) : 11'($urandom_range(9)));
        else if (r < 90)
            send_word(MODE_ANCHOR, b + 16'($urandom_range(4)), '0, '0, '0);
        else if (r < 95)
            send_word(2'($urandom_range(3)), 16'($urandom()), 11'($urandom()), rnd64(),
                      11'($urandom()));
        else
            send_word(MODE_INSERT, b - 16'($urandom_range(1, 40)),
                      11'($urandom_range(1, MAX_BYTES)), rnd64(), 11'($urandom_range(9)));
    endtask

    initial begin
        src_idle_pct = 14;
        snk_idle_pct = 67;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (80) @(negedge i_clk);

        // directed
        send_word(MODE_POP, '0, '0, '0, 11'd8);
        send_word(MODE_INSERT, 16'hFFFE, 11'd0, '1, '0);
        send_word(MODE_INSERT, 16'hFFFE, 11'd9, '1, '0);
        send_word(MODE_INSERT, 16'hFFFE, 11'h7FF, '1, '0);
        send_word(MODE_INSERT, 16'hFFFE, 11'd8, '1, '0);
        send_word(MODE_INSERT, 16'hFFFE, 11'd3, '0, '0);
        send_word(MODE_INSERT, 16'd1, 11'd1, 64'hA5A5_5A5A_F0F0_0F0F, '0);
        send_word(MODE_INSERT, 16'hFFF0, 11'd2, '1, '0);
        send_word(MODE_INSERT, 16'h003E, 11'd2, '1, '0);
        send_word(MODE_POP, '1, '1, '1, 11'd3);
        send_word(MODE_POP, '0, '0, '0, 11'h7FF);
        send_word(MODE_POP, '0, '0, '0, 11'd0);
        send_word(MODE_POP, '0, '0, '0, 11'd8);
        send_word(2'd3, '1, '1, '1, '1);
        send_word(MODE_ANCHOR, 16'hFFFF, '0, '0, '0);
        send_word(MODE_INSERT, 16'd5, 11'd4, 64'h0123_4567_89AB_CDEF, 11'd0);
        send_word(MODE_POP, '0, '0, '0, 11'd4);
        write_reg(CFG_HOLD, 16'd3);
        send_word(MODE_POP, '0, '0, '0, 11'd4);
        send_word(MODE_POP, '0, '0, '0, 11'd4);
        write_reg(CFG_WINDOW, 16'd1);
        send_word(MODE_INSERT, 16'd7, 11'd8, rnd64(), 11'd0);
        send_word(MODE_INSERT, 16'd8, 11'd8, rnd64(), 11'd0);
        send_word(MODE_POP, '0, '0, '0, 11'd8);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                src_idle_pct = 67;
                snk_idle_pct = 14;
            end else if (ph == 6) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case (ph)
                0: write_reg(CFG_WINDOW, 16'd64);
                1: write_reg(CFG_WINDOW, 16'd0);
                2: write_reg(CFG_WINDOW, 16'($urandom_range(2, 16)));
                3: write_reg(CFG_WINDOW, 16'd127);
                4: write_reg(CFG_WINDOW, 16'd65);
                5: write_reg(CFG_WINDOW, 16'($urandom_range(1, 64)));
                6: write_reg(CFG_WINDOW, 16'd2);
                default: write_reg(CFG_WINDOW, 16'd64);
            endcase
            case (ph % 4)
                0: write_reg(CFG_HOLD, 16'd0);
                1: write_reg(CFG_HOLD, 16'hFFFF);
                2: write_reg(CFG_HOLD, 16'd1);
                default: write_reg(CFG_HOLD, 16'($urandom()));
            endcase
            base = 16'($urandom());
            send_word(MODE_ANCHOR, base, '0, '0, '0);
            for (int n = 0; n < 200; n++) begin
                rand_word(base, (ph == 1) ? 2 : 64);
                if ($urandom_range(3) == 0) base = base + 16'($urandom_range(3));
                if (n == 100 && ph == 2) drain();
            end
        end

        drain();
        if (fail_cnt == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/rtpjb_pkg.sv
rtl/core/rtpjb_in_if.sv
rtl/core/rtpjb_out_if.sv
rtl/core/rtpjb_ram.sv
rtl/core/rtp_reorder_jitter_buffer.sv
dv/rtpjb_chk.sv
dv/tb_rtp_reorder_jitter_buffer.sv
